/* hdl/vlts_pkg.sv */
// Shared types and constants for the video line timing / status block.
// Holds the transaction structs, operation and offset codes and flag bit positions.
// No dependencies.
`default_nettype none

package vlts_pkg;

    // Line counter and match line width
    localparam int LINE_W  = 9;
    localparam int NUM_CPU = 2;

    // Default timing
    localparam int DRAWING_LINES_DEF  = 192;
    localparam int BLANKING_LINES_DEF = 71;
    localparam int RENDER_LEAD_DEF    = 48;

    // Operation codes
    localparam logic [1:0] OP_LINE_START = 2'd0;
    localparam logic [1:0] OP_HBLANK     = 2'd1;
    localparam logic [1:0] OP_READ       = 2'd2;
    localparam logic [1:0] OP_WRITE      = 2'd3;

    // Byte offsets
    localparam logic [1:0] OFF_STATUS   = 2'd0;
    localparam logic [1:0] OFF_MATCH_LO = 2'd1;
    localparam logic [1:0] OFF_LINE_LO  = 2'd2;
    localparam logic [1:0] OFF_LINE_HI  = 2'd3;

    // Bit positions in status flags and interrupt enables
    localparam int FLAG_VBLANK = 0;
    localparam int FLAG_HBLANK = 1;
    localparam int FLAG_MATCH  = 2;

    typedef struct packed {
        logic [1:0] op;
        logic       cpu_select;
        logic [1:0] byte_offset;
        logic [7:0] write_data;
    } t_vlts_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_a_vcount;
        logic       irq_a_vblank;
        logic       irq_a_hblank;
        logic       irq_b_vcount;
        logic       irq_b_vblank;
        logic       irq_b_hblank;
        logic       dma_vblank_req;
        logic       dma_hblank_req;
        logic       frame_end;
        logic       render_start;
    } t_vlts_out;

endpackage

`default_nettype wire

/* hdl/vlts_in_stage.sv */
// Input register stage: holds one accepted transaction until the engine takes it.
// Depends on vlts_pkg.
`default_nettype none

module vlts_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire vlts_pkg::t_vlts_in i_data,
    output logic                   o_valid,
    input  wire logic              i_take,
    output vlts_pkg::t_vlts_in      o_data
);
    import vlts_pkg::*;

    logic     r_valid;
    t_vlts_in r_data;
    logic     w_accept;

    // Full and not draining this cycle: hold off the sender
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* hdl/vlts_engine.sv */
// Timing state and status registers with the per-transaction update logic.
// Computes one result per transaction; state commits when i_fire is high.
// Depends on vlts_pkg.
`default_nettype none

module vlts_engine #(
    parameter int DRAWING_LINES  = vlts_pkg::DRAWING_LINES_DEF,
    parameter int BLANKING_LINES = vlts_pkg::BLANKING_LINES_DEF,
    parameter int RENDER_LEAD    = vlts_pkg::RENDER_LEAD_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire vlts_pkg::t_vlts_in i_item,
    output vlts_pkg::t_vlts_out     o_result
);
    import vlts_pkg::*;

    localparam int TOTAL_LINES = DRAWING_LINES + BLANKING_LINES;
    localparam int RENDER_LINE = TOTAL_LINES - RENDER_LEAD;
    localparam bit RENDER_OK   = (RENDER_LINE >= 0);

    localparam logic [LINE_W:0]   C_TOTAL_X  = (LINE_W + 1)'(TOTAL_LINES);
    localparam logic [LINE_W-1:0] C_DRAW     = LINE_W'(DRAWING_LINES);
    localparam logic [LINE_W-1:0] C_LAST     = LINE_W'(TOTAL_LINES - 1);
    localparam logic [LINE_W-1:0] C_RENDER   = RENDER_OK ? LINE_W'(RENDER_LINE) : '0;

    // State
    logic [LINE_W-1:0] r_line,  n_line;
    logic [LINE_W-1:0] r_match [NUM_CPU];
    logic [LINE_W-1:0] n_match [NUM_CPU];
    logic [2:0]        r_flags [NUM_CPU];
    logic [2:0]        n_flags [NUM_CPU];
    logic [2:0]        r_en    [NUM_CPU];
    logic [2:0]        n_en    [NUM_CPU];

    // Working signals
    logic [LINE_W:0]   w_sum;
    logic              w_wrap;
    logic [LINE_W-1:0] w_line_ev;
    logic              w_vb_hit;
    logic              w_vb_end;
    logic [NUM_CPU-1:0] w_vc_pulse;
    logic [NUM_CPU-1:0] w_vb_irq;
    logic [NUM_CPU-1:0] w_hb_irq;
    logic              w_dma_hb;
    logic [7:0]        w_rd;
    logic [LINE_W-1:0] w_sel_match;
    logic [2:0]        w_sel_flags;
    logic [2:0]        w_sel_en;

    // Next line value for a line-start event
    assign w_sum     = {1'b0, r_line} + (LINE_W + 1)'(1);
    assign w_wrap    = (w_sum >= C_TOTAL_X);
    assign w_line_ev = w_wrap ? '0 : w_sum[LINE_W-1:0];
    assign w_vb_hit  = (w_line_ev == C_DRAW);
    assign w_vb_end  = (w_line_ev == C_LAST);

    // Selected processor's register for reads
    assign w_sel_match = i_item.cpu_select ? r_match[1] : r_match[0];
    assign w_sel_flags = i_item.cpu_select ? r_flags[1] : r_flags[0];
    assign w_sel_en    = i_item.cpu_select ? r_en[1]    : r_en[0];

    // Read mux
    always_comb begin
        unique case (i_item.byte_offset)
            OFF_STATUS:   w_rd = {w_sel_match[LINE_W-1], 1'b0, w_sel_en, w_sel_flags};
            OFF_MATCH_LO: w_rd = w_sel_match[7:0];
            OFF_LINE_LO:  w_rd = r_line[7:0];
            OFF_LINE_HI:  w_rd = {7'd0, r_line[LINE_W-1]};
            default:      w_rd = '0;
        endcase
    end

    // Per-transaction update
    always_comb begin
        n_line     = r_line;
        n_match    = r_match;
        n_flags    = r_flags;
        n_en       = r_en;
        w_vc_pulse = '0;
        w_vb_irq   = '0;
        w_hb_irq   = '0;
        w_dma_hb   = 1'b0;
        o_result   = '0;

        unique case (i_item.op)
            OP_LINE_START: begin
                n_line                  = w_line_ev;
                o_result.frame_end      = w_wrap;
                o_result.dma_vblank_req = w_vb_hit;
                o_result.render_start   = RENDER_OK && (w_line_ev == C_RENDER);
                for (int c = 0; c < NUM_CPU; c++) begin
                    w_vc_pulse[c] = r_en[c][FLAG_MATCH] && !r_flags[c][FLAG_MATCH]
                                    && (r_match[c] == w_line_ev);
                    w_vb_irq[c]   = w_vb_hit && r_en[c][FLAG_VBLANK];
                    n_flags[c][FLAG_MATCH]  = (r_match[c] == w_line_ev);
                    n_flags[c][FLAG_VBLANK] = (r_flags[c][FLAG_VBLANK] || w_vb_hit)
                                              && !w_vb_end;
                    n_flags[c][FLAG_HBLANK] = 1'b0;
                end
            end
            OP_HBLANK: begin
                for (int c = 0; c < NUM_CPU; c++) begin
                    n_flags[c][FLAG_HBLANK] = 1'b1;
                    w_hb_irq[c] = r_en[c][FLAG_HBLANK];
                end
                w_dma_hb = (r_line < C_DRAW);
            end
            OP_READ: begin
                o_result.read_data = w_rd;
            end
            OP_WRITE: begin
                // Offsets two and three are line counter bytes: read only
                if (i_item.byte_offset == OFF_STATUS || i_item.byte_offset == OFF_MATCH_LO) begin
                    for (int c = 0; c < NUM_CPU; c++) begin
                        if (1'(c) == i_item.cpu_select) begin
                            if (i_item.byte_offset == OFF_STATUS) begin
                                n_en[c]              = i_item.write_data[5:3];
                                n_match[c][LINE_W-1] = i_item.write_data[7];
                            end else begin
                                n_match[c][7:0] = i_item.write_data;
                            end
                            w_vc_pulse[c] = n_en[c][FLAG_MATCH] && !r_flags[c][FLAG_MATCH]
                                            && (n_match[c] == r_line);
                            n_flags[c][FLAG_MATCH] = (n_match[c] == r_line);
                        end
                    end
                end
            end
            default: begin
                n_line = r_line;
            end
        endcase

        o_result.irq_a_vcount   = w_vc_pulse[0];
        o_result.irq_a_vblank   = w_vb_irq[0];
        o_result.irq_a_hblank   = w_hb_irq[0];
        o_result.irq_b_vcount   = w_vc_pulse[1];
        o_result.irq_b_vblank   = w_vb_irq[1];
        o_result.irq_b_hblank   = w_hb_irq[1];
        o_result.dma_hblank_req = w_dma_hb;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= LINE_W'(1);
            for (int c = 0; c < NUM_CPU; c++) begin
                r_match[c] <= '0;
                r_flags[c] <= '0;
                r_en[c]    <= '0;
            end
        end else if (i_fire) begin
            r_line  <= n_line;
            r_match <= n_match;
            r_flags <= n_flags;
            r_en    <= n_en;
        end
    end

endmodule

`default_nettype wire

/* hdl/vlts_out_stage.sv */
// Result register: holds one result transaction until the receiver takes it.
// Depends on vlts_pkg.
`default_nettype none

module vlts_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire vlts_pkg::t_vlts_out i_data,
    output logic                     o_ready,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output vlts_pkg::t_vlts_out      o_data
);
    import vlts_pkg::*;

    logic      r_valid;
    t_vlts_out r_data;

    // Can load when empty or when the held result leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* hdl/video_line_timing_status.sv */
// Top level of the scanline timing unit with per-processor display status registers.
// Instantiates vlts_in_stage, vlts_engine and vlts_out_stage; depends on vlts_pkg.
//
//   Channel   Valid        Stall        Payload
//   input     i_in_valid   o_in_stall   i_in_data  (t_vlts_in)
//   output    o_out_valid  i_out_stall  o_out_data (t_vlts_out)
//
// One transaction per cycle sustained while i_out_stall is low; a transaction passes
// the input register, then the engine's single-pass update into the result register.
// Synchronous active-low reset empties both stages; line counter resets to 1,
// match lines, flags and enables to 0.
// A stalled result holds in the result register; the input register still
// takes one more transaction, then o_in_stall rises.
`default_nettype none

module video_line_timing_status #(
    parameter int DRAWING_LINES  = vlts_pkg::DRAWING_LINES_DEF,
    parameter int BLANKING_LINES = vlts_pkg::BLANKING_LINES_DEF,
    parameter int RENDER_LEAD    = vlts_pkg::RENDER_LEAD_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire vlts_pkg::t_vlts_in  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output vlts_pkg::t_vlts_out      o_out_data
);
    import vlts_pkg::*;

    logic      w_in_valid;
    t_vlts_in  w_item;
    logic      w_out_ready;
    logic      w_take;
    t_vlts_out w_result;

    // Engine consumes the held transaction when the result register can load
    assign w_take = w_in_valid && w_out_ready;

    vlts_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (w_in_valid),
        .i_take  (w_take),
        .o_data  (w_item)
    );

    vlts_engine #(
        .DRAWING_LINES  (DRAWING_LINES),
        .BLANKING_LINES (BLANKING_LINES),
        .RENDER_LEAD    (RENDER_LEAD)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_take),
        .i_item   (w_item),
        .o_result (w_result)
    );

    vlts_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take),
        .i_data  (w_result),
        .o_ready (w_out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

    // Input side only stalls while it holds a transaction
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_in_valid)
        else $error("input stalled with empty input register");

    // Line-start pulses never coincide with hblank pulses
    a_line_vs_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.frame_end || o_out_data.dma_vblank_req ||
                         o_out_data.render_start))
        |-> !(o_out_data.irq_a_hblank || o_out_data.irq_b_hblank ||
              o_out_data.dma_hblank_req))
        else $error("line-start and hblank pulses in one result");

    // Nonzero read data only on reads: no vcount, frame-end, hblank or vblank DMA pulse goes with it
    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.read_data != 8'd0))
        |-> !(o_out_data.irq_a_vcount || o_out_data.irq_b_vcount ||
              o_out_data.frame_end || o_out_data.irq_a_hblank ||
              o_out_data.irq_b_hblank || o_out_data.dma_vblank_req))
        else $error("read data together with event pulses");

    // A taken transaction always lands in the result register
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_out_valid)
        else $error("result lost after engine update");

endmodule

`default_nettype wire
